[hw/rtl/tkbd_pkg.sv]
// Shared types and constants for the terminal key byte decoder.
// Used by the controller, the plain-byte unit, the datapath and the top level.
// No dependencies.
package tkbd_pkg;

    // Bytes with special meaning
    localparam logic [7:0] C_ESC      = 8'h1B;
    localparam logic [7:0] C_CR       = 8'h0D;
    localparam logic [7:0] C_LF       = 8'h0A;
    localparam logic [7:0] C_DEL      = 8'h7F;
    localparam logic [7:0] C_BS       = 8'h08;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_SS3_O    = 8'h4F;
    localparam logic [7:0] C_TILDE    = 8'h7E;
    localparam logic [7:0] C_DIGIT_LO = 8'h30;
    localparam logic [7:0] C_DIGIT_HI = 8'h39;
    localparam logic [3:0] C_DIGIT_HN = 4'h3;
    localparam logic [7:0] C_FIN_A    = 8'h41;
    localparam logic [7:0] C_FIN_B    = 8'h42;
    localparam logic [7:0] C_FIN_C    = 8'h43;
    localparam logic [7:0] C_FIN_D    = 8'h44;
    localparam logic [7:0] C_FIN_H    = 8'h48;
    localparam logic [7:0] C_FIN_F    = 8'h46;

    // UTF-8 prefix masks and patterns
    localparam logic [7:0] C_MASK_CONT  = 8'h3F;
    localparam logic [7:0] C_MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] C_MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] C_MASK_LEAD4 = 8'h07;
    localparam logic [7:0] C_PFX_CONT_M = 8'hC0;
    localparam logic [7:0] C_PFX_CONT   = 8'h80;
    localparam logic [7:0] C_PFX_2B_M   = 8'hE0;
    localparam logic [7:0] C_PFX_2B     = 8'hC0;
    localparam logic [7:0] C_PFX_3B_M   = 8'hF0;
    localparam logic [7:0] C_PFX_3B     = 8'hE0;
    localparam logic [7:0] C_PFX_4B_M   = 8'hF8;
    localparam logic [7:0] C_PFX_4B     = 8'hF0;

    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] C_CP_PRINT_MIN = 21'h00020;
    localparam logic [CP_W-1:0] C_CP_TAB       = 21'h00009;

    // Output tdata: kind (4) + code point (21), padded to 32
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_PAD_W   = 7;

    typedef enum logic [3:0] {
        K_CHAR      = 4'd0,
        K_UP        = 4'd1,
        K_DOWN      = 4'd2,
        K_RIGHT     = 4'd3,
        K_LEFT      = 4'd4,
        K_HOME      = 4'd5,
        K_END       = 4'd6,
        K_DELETE    = 4'd7,
        K_BACKSPACE = 4'd8,
        K_ENTER     = 4'd9
    } t_key_kind;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic decode;
        logic replay;
        logic flush;
    } t_tkbd_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic abandon;
        logic replay_last;
        logic hold_v;
        logic out_free;
        logic can_step;
    } t_tkbd_sts;

endpackage

[hw/rtl/tkbd_plain.sv]
// Plain-byte unit: Enter/Backspace/ESC detection and the UTF-8 decoder step.
// Purely combinational; the UTF-8 state registers live in tkbd_dp.
// Depends on tkbd_pkg.
module tkbd_plain (
    input  logic [7:0]                    i_byte,
    input  logic [1:0]                    i_u8_rem,
    input  logic [tkbd_pkg::CP_W-1:0]     i_cp_acc,
    output logic                          o_ev_v,
    output tkbd_pkg::t_key_kind           o_ev_kind,
    output logic [tkbd_pkg::CP_W-1:0]     o_ev_cp,
    output logic                          o_set_esc,
    output logic [1:0]                    o_u8_rem,
    output logic [tkbd_pkg::CP_W-1:0]     o_cp_acc
);

    logic                          w_done;
    logic [tkbd_pkg::CP_W-1:0]     w_cp;
    logic [tkbd_pkg::CP_W-1:0]     w_shift;

    // accumulator with the next six payload bits shifted in
    assign w_shift = {i_cp_acc[tkbd_pkg::CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_ev_v    = 1'b0;
        o_ev_kind = tkbd_pkg::K_CHAR;
        o_ev_cp   = '0;
        o_set_esc = 1'b0;
        o_u8_rem  = i_u8_rem;
        o_cp_acc  = i_cp_acc;
        w_done    = 1'b0;
        w_cp      = '0;

        if (i_byte == tkbd_pkg::C_ESC) begin
            o_set_esc = 1'b1;
        end else if (i_byte == tkbd_pkg::C_CR || i_byte == tkbd_pkg::C_LF) begin
            o_ev_v    = 1'b1;
            o_ev_kind = tkbd_pkg::K_ENTER;
        end else if (i_byte == tkbd_pkg::C_DEL || i_byte == tkbd_pkg::C_BS) begin
            o_ev_v    = 1'b1;
            o_ev_kind = tkbd_pkg::K_BACKSPACE;
        end else if (i_u8_rem == 2'd0) begin
            // start of a character
            if (!i_byte[7]) begin
                w_cp   = tkbd_pkg::CP_W'(i_byte);
                w_done = 1'b1;
            end else if ((i_byte & tkbd_pkg::C_PFX_2B_M) == tkbd_pkg::C_PFX_2B) begin
                o_cp_acc = tkbd_pkg::CP_W'(i_byte & tkbd_pkg::C_MASK_LEAD2);
                o_u8_rem = 2'd1;
            end else if ((i_byte & tkbd_pkg::C_PFX_3B_M) == tkbd_pkg::C_PFX_3B) begin
                o_cp_acc = tkbd_pkg::CP_W'(i_byte & tkbd_pkg::C_MASK_LEAD3);
                o_u8_rem = 2'd2;
            end else if ((i_byte & tkbd_pkg::C_PFX_4B_M) == tkbd_pkg::C_PFX_4B) begin
                o_cp_acc = tkbd_pkg::CP_W'(i_byte & tkbd_pkg::C_MASK_LEAD4);
                o_u8_rem = 2'd3;
            end
        end else if ((i_byte & tkbd_pkg::C_PFX_CONT_M) != tkbd_pkg::C_PFX_CONT) begin
            // broken sequence: drop it and this byte
            o_u8_rem = 2'd0;
        end else begin
            o_cp_acc = w_shift;
            o_u8_rem = i_u8_rem - 2'd1;
            if (i_u8_rem == 2'd1) begin
                w_cp   = w_shift;
                w_done = 1'b1;
            end
        end

        // printable code points and tab become Char events
        if (w_done && (w_cp >= tkbd_pkg::C_CP_PRINT_MIN || w_cp == tkbd_pkg::C_CP_TAB)) begin
            o_ev_v    = 1'b1;
            o_ev_kind = tkbd_pkg::K_CHAR;
            o_ev_cp   = w_cp;
        end
    end

endmodule

[hw/rtl/tkbd_ctrl.sv]
// Sequencer for the key decoder: accept, decode, replay and flush phases.
// Talks to tkbd_dp through command and status structs.
// Depends on tkbd_pkg.
module tkbd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  tkbd_pkg::t_tkbd_sts   i_sts,
    output tkbd_pkg::t_tkbd_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_REPLAY = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.can_step) begin
                    o_cmd.decode = 1'b1;
                    n_state      = i_sts.abandon ? S_REPLAY : S_FLUSH;
                end
            end
            S_REPLAY: begin
                if (i_sts.can_step) begin
                    o_cmd.replay = 1'b1;
                    if (i_sts.replay_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // last held event goes out marked as end of run
                if (!i_sts.hold_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/tkbd_dp.sv]
// Datapath: escape tracker, held digits, replay index, UTF-8 state,
// one-event hold stage and output register. Depends on tkbd_pkg, tkbd_plain.
module tkbd_dp #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tkbd_pkg::t_tkbd_cmd               i_cmd,
    output tkbd_pkg::t_tkbd_sts               o_sts,
    input  logic [7:0]                        i_byte,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [tkbd_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic                              o_tlast
);

    localparam int unsigned CW  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned RW  = $clog2(MAX_DIGITS + 2);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ESC  = 5'b00010,
        PH_CSI  = 5'b00100,
        PH_SS3  = 5'b01000,
        PH_DIG  = 5'b10000
    } t_esc_phase;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_CSI  = 2'd1,
        LEAD_SS3  = 2'd2
    } t_lead;

    // control state
    t_esc_phase                 r_phase, n_phase;
    logic [CW-1:0]              r_dcnt, n_dcnt;
    logic [1:0]                 r_u8_rem, n_u8_rem;
    logic [tkbd_pkg::CP_W-1:0]  r_cp_acc, n_cp_acc;
    logic [RW-1:0]              r_ridx, n_ridx;
    logic                       r_hold_v, n_hold_v;
    logic                       r_out_v, n_out_v;
    // payload
    logic [7:0]                 r_byte, n_byte;
    t_lead                      r_lead, n_lead;
    logic [CW-1:0]              r_rcnt, n_rcnt;
    tkbd_pkg::t_key_kind        r_hold_kind, n_hold_kind;
    logic [tkbd_pkg::CP_W-1:0]  r_hold_cp, n_hold_cp;
    tkbd_pkg::t_key_kind        r_out_kind, n_out_kind;
    logic [tkbd_pkg::CP_W-1:0]  r_out_cp, n_out_cp;
    logic                       r_out_last, n_out_last;
    logic [3:0]                 r_digits [MAX_DIGITS];

    logic                       w_fk_hit;
    tkbd_pkg::t_key_kind        w_fk;
    logic                       w_is_dig;
    logic                       w_is_tilde;
    logic                       w_dcnt_room;
    logic                       w_abandon;
    t_lead                      w_lead;
    logic [RW-1:0]              w_ridx_m1;
    logic [RW-1:0]              w_ridx_end;
    logic [7:0]                 w_rep_byte;
    logic [7:0]                 w_pl_byte;
    logic                       w_dig_we;
    logic [DIW-1:0]             w_dig_widx;
    logic                       w_out_free;
    logic                       w_ev_v;
    tkbd_pkg::t_key_kind        w_ev_kind;
    logic [tkbd_pkg::CP_W-1:0]  w_ev_cp;

    logic                       w_pl_ev_v;
    tkbd_pkg::t_key_kind        w_pl_ev_kind;
    logic [tkbd_pkg::CP_W-1:0]  w_pl_ev_cp;
    logic                       w_pl_set_esc;
    logic [1:0]                 w_pl_u8_rem;
    logic [tkbd_pkg::CP_W-1:0]  w_pl_cp_acc;

    // final byte of an arrow / Home / End sequence
    always_comb begin
        w_fk_hit = 1'b1;
        w_fk     = tkbd_pkg::K_CHAR;
        case (r_byte)
            tkbd_pkg::C_FIN_A: w_fk = tkbd_pkg::K_UP;
            tkbd_pkg::C_FIN_B: w_fk = tkbd_pkg::K_DOWN;
            tkbd_pkg::C_FIN_C: w_fk = tkbd_pkg::K_RIGHT;
            tkbd_pkg::C_FIN_D: w_fk = tkbd_pkg::K_LEFT;
            tkbd_pkg::C_FIN_H: w_fk = tkbd_pkg::K_HOME;
            tkbd_pkg::C_FIN_F: w_fk = tkbd_pkg::K_END;
            default:           w_fk_hit = 1'b0;
        endcase
    end

    assign w_is_dig    = (r_byte >= tkbd_pkg::C_DIGIT_LO) && (r_byte <= tkbd_pkg::C_DIGIT_HI);
    assign w_is_tilde  = (r_byte == tkbd_pkg::C_TILDE);
    assign w_dcnt_room = (r_dcnt < CW'(MAX_DIGITS));

    // mismatch detection for the pending escape sequence
    always_comb begin
        w_abandon = 1'b0;
        w_lead    = LEAD_NONE;
        case (r_phase)
            PH_ESC: begin
                w_abandon = !(r_byte == tkbd_pkg::C_LBRACKET || r_byte == tkbd_pkg::C_SS3_O);
            end
            PH_CSI: begin
                w_abandon = !w_fk_hit && !w_is_dig && !w_is_tilde;
                w_lead    = LEAD_CSI;
            end
            PH_SS3: begin
                w_abandon = !w_fk_hit;
                w_lead    = LEAD_SS3;
            end
            PH_DIG: begin
                w_abandon = (w_is_dig && !w_dcnt_room) || (!w_is_dig && !w_is_tilde);
                w_lead    = LEAD_CSI;
            end
            default: begin
                w_abandon = 1'b0;
            end
        endcase
    end

    // replay order: lead byte, held digits, then the mismatching byte
    assign w_ridx_m1  = r_ridx - RW'(1);
    assign w_ridx_end = RW'(r_rcnt) + RW'(1);

    always_comb begin
        if (r_ridx == '0) begin
            w_rep_byte = (r_lead == LEAD_SS3) ? tkbd_pkg::C_SS3_O : tkbd_pkg::C_LBRACKET;
        end else if (r_ridx == w_ridx_end) begin
            w_rep_byte = r_byte;
        end else begin
            w_rep_byte = {tkbd_pkg::C_DIGIT_HN, r_digits[w_ridx_m1[DIW-1:0]]};
        end
    end

    assign w_pl_byte = i_cmd.replay ? w_rep_byte : r_byte;

    tkbd_plain u_plain (
        .i_byte    (w_pl_byte),
        .i_u8_rem  (r_u8_rem),
        .i_cp_acc  (r_cp_acc),
        .o_ev_v    (w_pl_ev_v),
        .o_ev_kind (w_pl_ev_kind),
        .o_ev_cp   (w_pl_ev_cp),
        .o_set_esc (w_pl_set_esc),
        .o_u8_rem  (w_pl_u8_rem),
        .o_cp_acc  (w_pl_cp_acc)
    );

    // digit capture
    assign w_dig_we   = i_cmd.decode && w_is_dig &&
                        ((r_phase == PH_CSI) || (r_phase == PH_DIG && w_dcnt_room));
    assign w_dig_widx = (r_phase == PH_CSI) ? '0 : r_dcnt[DIW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_digits[w_dig_widx] <= r_byte[3:0];
        end
    end

    assign w_out_free = !r_out_v || i_tready;

    // next-state logic for the sequence tracker, hold stage and output
    always_comb begin
        n_phase     = r_phase;
        n_dcnt      = r_dcnt;
        n_u8_rem    = r_u8_rem;
        n_cp_acc    = r_cp_acc;
        n_ridx      = r_ridx;
        n_hold_v    = r_hold_v;
        n_out_v     = r_out_v;
        n_byte      = r_byte;
        n_lead      = r_lead;
        n_rcnt      = r_rcnt;
        n_hold_kind = r_hold_kind;
        n_hold_cp   = r_hold_cp;
        n_out_kind  = r_out_kind;
        n_out_cp    = r_out_cp;
        n_out_last  = r_out_last;
        w_ev_v      = 1'b0;
        w_ev_kind   = tkbd_pkg::K_CHAR;
        w_ev_cp     = '0;

        if (i_cmd.load) begin
            n_byte = i_byte;
        end

        // one step on the request byte
        if (i_cmd.decode) begin
            case (r_phase)
                PH_ESC: begin
                    if (r_byte == tkbd_pkg::C_LBRACKET) begin
                        n_phase = PH_CSI;
                        n_dcnt  = '0;
                    end else if (r_byte == tkbd_pkg::C_SS3_O) begin
                        n_phase = PH_SS3;
                    end
                end
                PH_CSI: begin
                    if (w_fk_hit) begin
                        n_phase   = PH_IDLE;
                        w_ev_v    = 1'b1;
                        w_ev_kind = w_fk;
                    end else if (w_is_dig) begin
                        n_dcnt  = CW'(1);
                        n_phase = PH_DIG;
                    end else if (w_is_tilde) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SS3: begin
                    if (w_fk_hit) begin
                        n_phase   = PH_IDLE;
                        w_ev_v    = 1'b1;
                        w_ev_kind = w_fk;
                    end
                end
                PH_DIG: begin
                    if (w_is_dig && w_dcnt_room) begin
                        n_dcnt = r_dcnt + CW'(1);
                    end else if (w_is_tilde) begin
                        // single-digit codes 1, 4 and 3 name keys
                        if (r_dcnt == CW'(1)) begin
                            if (r_digits[0] == 4'd1) begin
                                w_ev_v    = 1'b1;
                                w_ev_kind = tkbd_pkg::K_HOME;
                            end else if (r_digits[0] == 4'd4) begin
                                w_ev_v    = 1'b1;
                                w_ev_kind = tkbd_pkg::K_END;
                            end else if (r_digits[0] == 4'd3) begin
                                w_ev_v    = 1'b1;
                                w_ev_kind = tkbd_pkg::K_DELETE;
                            end
                        end
                        n_dcnt  = '0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase   = w_pl_set_esc ? PH_ESC : PH_IDLE;
                    n_u8_rem  = w_pl_u8_rem;
                    n_cp_acc  = w_pl_cp_acc;
                    w_ev_v    = w_pl_ev_v;
                    w_ev_kind = w_pl_ev_kind;
                    w_ev_cp   = w_pl_ev_cp;
                end
            endcase

            // mismatch: drop the ESC and set up the replay
            if (w_abandon) begin
                n_phase = PH_IDLE;
                n_dcnt  = '0;
                n_rcnt  = r_dcnt;
                n_lead  = w_lead;
                n_ridx  = (w_lead == LEAD_NONE) ? RW'(1) : '0;
            end
        end

        // one replayed byte through the plain-byte unit
        if (i_cmd.replay) begin
            n_u8_rem  = w_pl_u8_rem;
            n_cp_acc  = w_pl_cp_acc;
            w_ev_v    = w_pl_ev_v;
            w_ev_kind = w_pl_ev_kind;
            w_ev_cp   = w_pl_ev_cp;
            n_ridx    = r_ridx + RW'(1);
            if (w_pl_set_esc) begin
                n_phase = PH_ESC;
            end
        end

        // output register drains
        if (r_out_v && i_tready) begin
            n_out_v = 1'b0;
        end

        // new event: the held one moves out as not-last
        if (w_ev_v) begin
            if (r_hold_v) begin
                n_out_v    = 1'b1;
                n_out_kind = r_hold_kind;
                n_out_cp   = r_hold_cp;
                n_out_last = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_kind = w_ev_kind;
            n_hold_cp   = w_ev_cp;
        end

        // end of run: held event moves out as last
        if (i_cmd.flush) begin
            n_out_v    = 1'b1;
            n_out_kind = r_hold_kind;
            n_out_cp   = r_hold_cp;
            n_out_last = 1'b1;
            n_hold_v   = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_dcnt   <= '0;
            r_u8_rem <= '0;
            r_cp_acc <= '0;
            r_ridx   <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_dcnt   <= n_dcnt;
            r_u8_rem <= n_u8_rem;
            r_cp_acc <= n_cp_acc;
            r_ridx   <= n_ridx;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_lead      <= n_lead;
        r_rcnt      <= n_rcnt;
        r_hold_kind <= n_hold_kind;
        r_hold_cp   <= n_hold_cp;
        r_out_kind  <= n_out_kind;
        r_out_cp    <= n_out_cp;
        r_out_last  <= n_out_last;
    end

    // status to the controller
    always_comb begin
        o_sts.abandon     = w_abandon;
        o_sts.replay_last = (r_ridx == w_ridx_end);
        o_sts.hold_v      = r_hold_v;
        o_sts.out_free    = w_out_free;
        o_sts.can_step    = !r_hold_v || w_out_free;
    end

    assign o_tvalid = r_out_v;
    assign o_tdata  = {{tkbd_pkg::OUT_PAD_W{1'b0}}, r_out_cp, r_out_kind};
    assign o_tlast  = r_out_last;

endmodule

[hw/rtl/terminal_key_byte_decoder.sv]
// Top level of the terminal key byte decoder.
// Instantiates tkbd_ctrl and tkbd_dp; depends on tkbd_pkg.
//
// Turns raw terminal bytes into key events (Enter, Backspace, arrows, Home,
// End, Delete and UTF-8 characters). One byte is taken at a time and goes
// through the accept, decode and flush steps. When an escape sequence
// breaks, the ESC is dropped and the held bytes are replayed through the
// single plain-byte decoder between decode and flush, one byte per cycle
// while the output does not stall. Events leave through an output register
// backed by a one-event hold stage; a stalled output holds the sequencer.
// The last event caused by a byte carries tlast.
module terminal_key_byte_decoder #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] in_byte
    input  logic [7:0]                        i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [3:0] key_kind, [24:4] code_point, [31:25] zero
    output logic [tkbd_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    tkbd_pkg::t_tkbd_cmd w_cmd;
    tkbd_pkg::t_tkbd_sts w_sts;

    tkbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tkbd_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_byte   (i_s_axis_tdata),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // no event may be left over when a new request is taken
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_sts.hold_v)
        else $error("event still held while accepting a new byte");

    // steps only when the hold stage can make room
    a_step_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.decode || w_cmd.replay || w_cmd.flush) |-> w_sts.can_step)
        else $error("step issued while the output register is full");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.decode, w_cmd.replay, w_cmd.flush}))
        else $error("more than one command issued");

    // a flush puts an end-of-run event on the output
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("flush did not present the last event");

endmodule

[tb/sv/tb_terminal_key_byte_decoder.sv]
// Self-checking testbench for terminal_key_byte_decoder: drives raw terminal bytes,
// predicts the key events they cause and checks every event on the output stream.
// Depends on tkbd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_terminal_key_byte_decoder;

    localparam int unsigned MAX_DIGITS   = 8;
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          SETTLE_CYCLES = MAX_DIGITS + 12;
    localparam int          RANDOM_BYTES = 410;
    localparam logic [7:0]  NO_LEAD      = 8'h00;
    localparam logic [7:0]  C_TAB        = 8'h09;

    // Escape parser phases of the predictor
    typedef enum logic [2:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_CSI,
        ESC_SS3,
        ESC_DIGITS
    } t_esc_phase;

    typedef struct {
        tkbd_pkg::t_key_kind         kind;
        logic [tkbd_pkg::CP_W-1:0]   cp;
        logic                        last;
    } t_key_event;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire [tkbd_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire         m_tlast;

    // Predictor state
    t_esc_phase                 esc_phase = ESC_NONE;
    logic [3:0]                 csi_digits [MAX_DIGITS];
    int                         csi_ndigits = 0;
    logic [1:0]                 utf_left = 2'd0;
    logic [tkbd_pkg::CP_W-1:0]  utf_acc = '0;

    t_key_event  byte_keys[$];
    t_key_event  expected_keys[$];

    bit  gaps_on = 1'b0;
    int  fail_count = 0;
    int  bytes_sent = 0;
    int  events_checked = 0;
    int  cycle_count = 0;

    terminal_key_byte_decoder #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Key event predictor
    // ------------------------------------------------------------------
    function automatic void add_key(input tkbd_pkg::t_key_kind kind,
                                    input logic [tkbd_pkg::CP_W-1:0] cp);
        t_key_event ev;
        ev.kind = kind;
        ev.cp   = cp;
        ev.last = 1'b0;
        byte_keys.push_back(ev);
    endfunction

    function automatic void utf8_byte(input logic [7:0] b);
        logic                      done;
        logic [tkbd_pkg::CP_W-1:0] cp;
        done = 1'b0;
        cp   = '0;
        if (utf_left == 2'd0) begin
            if (!b[7]) begin
                cp   = {13'd0, b};
                done = 1'b1;
            end else if ((b & tkbd_pkg::C_PFX_2B_M) == tkbd_pkg::C_PFX_2B) begin
                utf_acc  = {13'd0, b & tkbd_pkg::C_MASK_LEAD2};
                utf_left = 2'd1;
            end else if ((b & tkbd_pkg::C_PFX_3B_M) == tkbd_pkg::C_PFX_3B) begin
                utf_acc  = {13'd0, b & tkbd_pkg::C_MASK_LEAD3};
                utf_left = 2'd2;
            end else if ((b & tkbd_pkg::C_PFX_4B_M) == tkbd_pkg::C_PFX_4B) begin
                utf_acc  = {13'd0, b & tkbd_pkg::C_MASK_LEAD4};
                utf_left = 2'd3;
            end
        end else if ((b & tkbd_pkg::C_PFX_CONT_M) != tkbd_pkg::C_PFX_CONT) begin
            // broken continuation: drop the pending character and this byte
            utf_left = 2'd0;
        end else begin
            utf_acc  = {utf_acc[tkbd_pkg::CP_W-7:0], b[5:0]};
            utf_left = utf_left - 2'd1;
            if (utf_left == 2'd0) begin
                cp   = utf_acc;
                done = 1'b1;
            end
        end
        if (done && (cp >= tkbd_pkg::C_CP_PRINT_MIN || cp == tkbd_pkg::C_CP_TAB))
            add_key(tkbd_pkg::K_CHAR, cp);
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == tkbd_pkg::C_ESC)
            esc_phase = ESC_SEEN;
        else if (b == tkbd_pkg::C_CR || b == tkbd_pkg::C_LF)
            add_key(tkbd_pkg::K_ENTER, '0);
        else if (b == tkbd_pkg::C_DEL || b == tkbd_pkg::C_BS)
            add_key(tkbd_pkg::K_BACKSPACE, '0);
        else
            utf8_byte(b);
    endfunction

    // Broken sequence: ESC dropped, held bytes and the current byte replayed
    function automatic void abandon_escape(input logic [7:0] lead, input logic [7:0] b);
        int n;
        n = csi_ndigits;
        esc_phase   = ESC_NONE;
        csi_ndigits = 0;
        if (lead != NO_LEAD)
            plain_byte(lead);
        for (int i = 0; i < n; i++)
            plain_byte({tkbd_pkg::C_DIGIT_HN, csi_digits[i]});
        plain_byte(b);
    endfunction

    function automatic logic cursor_key(input logic [7:0] b,
                                        output tkbd_pkg::t_key_kind kind);
        kind = tkbd_pkg::K_CHAR;
        case (b)
            tkbd_pkg::C_FIN_A: kind = tkbd_pkg::K_UP;
            tkbd_pkg::C_FIN_B: kind = tkbd_pkg::K_DOWN;
            tkbd_pkg::C_FIN_C: kind = tkbd_pkg::K_RIGHT;
            tkbd_pkg::C_FIN_D: kind = tkbd_pkg::K_LEFT;
            tkbd_pkg::C_FIN_H: kind = tkbd_pkg::K_HOME;
            tkbd_pkg::C_FIN_F: kind = tkbd_pkg::K_END;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void predict_keys(input logic [7:0] b);
        tkbd_pkg::t_key_kind kind;
        logic                is_digit;
        is_digit = (b >= tkbd_pkg::C_DIGIT_LO && b <= tkbd_pkg::C_DIGIT_HI);
        byte_keys.delete();
        case (esc_phase)
            ESC_SEEN: begin
                if (b == tkbd_pkg::C_LBRACKET) begin
                    esc_phase   = ESC_CSI;
                    csi_ndigits = 0;
                end else if (b == tkbd_pkg::C_SS3_O) begin
                    esc_phase = ESC_SS3;
                end else begin
                    abandon_escape(NO_LEAD, b);
                end
            end
            ESC_CSI: begin
                if (cursor_key(b, kind)) begin
                    esc_phase = ESC_NONE;
                    add_key(kind, '0);
                end else if (is_digit) begin
                    csi_digits[0] = b[3:0];
                    csi_ndigits   = 1;
                    esc_phase     = ESC_DIGITS;
                end else if (b == tkbd_pkg::C_TILDE) begin
                    esc_phase = ESC_NONE;
                end else begin
                    abandon_escape(tkbd_pkg::C_LBRACKET, b);
                end
            end
            ESC_SS3: begin
                if (cursor_key(b, kind)) begin
                    esc_phase = ESC_NONE;
                    add_key(kind, '0);
                end else begin
                    abandon_escape(tkbd_pkg::C_SS3_O, b);
                end
            end
            ESC_DIGITS: begin
                if (is_digit) begin
                    if (csi_ndigits < MAX_DIGITS) begin
                        csi_digits[csi_ndigits] = b[3:0];
                        csi_ndigits++;
                    end else begin
                        abandon_escape(tkbd_pkg::C_LBRACKET, b);
                    end
                end else if (b == tkbd_pkg::C_TILDE) begin
                    if (csi_ndigits == 1) begin
                        case (csi_digits[0])
                            4'd1:    add_key(tkbd_pkg::K_HOME, '0);
                            4'd4:    add_key(tkbd_pkg::K_END, '0);
                            4'd3:    add_key(tkbd_pkg::K_DELETE, '0);
                            default: ;
                        endcase
                    end
                    csi_ndigits = 0;
                    esc_phase   = ESC_NONE;
                end else begin
                    abandon_escape(tkbd_pkg::C_LBRACKET, b);
                end
            end
            default: begin
                esc_phase = ESC_NONE;
                plain_byte(b);
            end
        endcase
        if (byte_keys.size() > 0)
            byte_keys[byte_keys.size()-1].last = 1'b1;
        foreach (byte_keys[i])
            expected_keys.push_back(byte_keys[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One byte request; tvalid stays high after acceptance so that a back-to-back
    // request needs no second assignment in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (s_tready !== 1'b1);
        predict_keys(b);
        bytes_sent++;
    endtask

    // Ends the request stream and waits until every predicted event has left
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output back-pressure
    initial begin : out_ready
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 99) < 30)
                    stall = pick_gap();
            end
        end
    end

    // Event checker
    always @(posedge clk) begin : event_check
        t_key_event want;
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (expected_keys.size() == 0) begin
                $error("unexpected key event: tdata=%h tlast=%b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = expected_keys.pop_front();
                events_checked++;
                if (m_tdata[3:0] !== want.kind) begin
                    $error("key_kind: expected %0d, got %0d", want.kind, m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[24:4] !== want.cp) begin
                    $error("code_point: expected %h, got %h", want.cp, m_tdata[24:4]);
                    fail_count++;
                end
                if (m_tdata[tkbd_pkg::OUT_TDATA_W-1 -: tkbd_pkg::OUT_PAD_W] !== '0) begin
                    $error("tdata padding: expected 0, got %h",
                           m_tdata[tkbd_pkg::OUT_TDATA_W-1 -: tkbd_pkg::OUT_PAD_W]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, expected_keys.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] cursor_final();
        case ($urandom_range(0, 5))
            0:       return tkbd_pkg::C_FIN_A;
            1:       return tkbd_pkg::C_FIN_B;
            2:       return tkbd_pkg::C_FIN_C;
            3:       return tkbd_pkg::C_FIN_D;
            4:       return tkbd_pkg::C_FIN_H;
            default: return tkbd_pkg::C_FIN_F;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return {tkbd_pkg::C_DIGIT_HN, 4'($urandom_range(0, 9))};
    endfunction

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_byte(rand_digit());
    endtask

    // Well-formed cursor / editing escape with random content
    task automatic send_escape_good();
        int r;
        r = $urandom_range(0, 9);
        send_byte(tkbd_pkg::C_ESC);
        if (r < 3) begin
            send_byte(tkbd_pkg::C_LBRACKET);
            send_byte(cursor_final());
        end else if (r < 5) begin
            send_byte(tkbd_pkg::C_SS3_O);
            send_byte(cursor_final());
        end else begin
            send_byte(tkbd_pkg::C_LBRACKET);
            r = $urandom_range(0, 9);
            if (r < 5)
                send_byte({tkbd_pkg::C_DIGIT_HN, ($urandom_range(0, 2) == 0) ? 4'd1 :
                           ($urandom_range(0, 1) == 0) ? 4'd3 : 4'd4});
            else if (r < 7)
                send_digits(1);
            else if (r < 9)
                send_digits($urandom_range(2, MAX_DIGITS));
            send_byte(tkbd_pkg::C_TILDE);
        end
    endtask

    // Escape that breaks off somewhere, including digit overflow
    task automatic send_escape_broken();
        send_byte(tkbd_pkg::C_ESC);
        case ($urandom_range(0, 4))
            0: send_byte(8'($urandom_range(0, 255)));
            1: begin
                send_byte(tkbd_pkg::C_LBRACKET);
                send_byte(8'($urandom_range(0, 255)));
            end
            2: begin
                send_byte(tkbd_pkg::C_SS3_O);
                send_byte(8'($urandom_range(0, 255)));
            end
            3: begin
                send_byte(tkbd_pkg::C_LBRACKET);
                send_digits($urandom_range(1, MAX_DIGITS));
                send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                send_byte(tkbd_pkg::C_LBRACKET);
                send_digits(MAX_DIGITS + 1);
            end
        endcase
    endtask

    // Well-formed UTF-8 character of 1 to 4 bytes with random payload bits
    task automatic send_utf8_good();
        int n;
        n = $urandom_range(1, 4);
        case (n)
            1:       send_byte(8'($urandom_range(32, 126)));
            2:       send_byte(tkbd_pkg::C_PFX_2B | 8'($urandom_range(0, 31)));
            3:       send_byte(tkbd_pkg::C_PFX_3B | 8'($urandom_range(0, 15)));
            default: send_byte(tkbd_pkg::C_PFX_4B | 8'($urandom_range(0, 7)));
        endcase
        for (int i = 1; i < n; i++)
            send_byte(tkbd_pkg::C_PFX_CONT | 8'($urandom_range(0, 63)));
    endtask

    // Truncated sequence or stray continuation byte
    task automatic send_utf8_broken();
        int n;
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
            send_byte(tkbd_pkg::C_PFX_CONT | 8'($urandom_range(0, 63)));
        end else begin
            case (n)
                1:       send_byte(tkbd_pkg::C_PFX_2B | 8'($urandom_range(0, 31)));
                2:       send_byte(tkbd_pkg::C_PFX_3B | 8'($urandom_range(0, 15)));
                default: send_byte(tkbd_pkg::C_PFX_4B | 8'($urandom_range(0, 7)));
            endcase
            for (int i = 1; i < n; i++)
                send_byte(tkbd_pkg::C_PFX_CONT | 8'($urandom_range(0, 63)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Enter, Backspace, tab and a control byte with no event
    task automatic test_plain_keys();
        gaps_on = 1'b0;
        send_byte(tkbd_pkg::C_CR);
        send_byte(tkbd_pkg::C_LF);
        send_byte(tkbd_pkg::C_DEL);
        send_byte(tkbd_pkg::C_BS);
        send_byte(C_TAB);
        send_byte(8'h1F);
        wait_drained();
    endtask

    // Largest code point, Enter inside a sequence, bad continuation, bad starts
    task automatic test_utf8_decode();
        gaps_on = 1'b1;
        send_byte(8'hF7);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hC3);
        send_byte(tkbd_pkg::C_CR);
        send_byte(8'hA9);
        send_byte(8'hE2);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h80);
        wait_drained();
    endtask

    // Cursor keys, Delete, empty and unknown numeric sequences
    task automatic test_escape_keys();
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte(tkbd_pkg::C_FIN_A);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_SS3_O);
        send_byte(tkbd_pkg::C_FIN_H);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte({tkbd_pkg::C_DIGIT_HN, 4'd3});
        send_byte(tkbd_pkg::C_TILDE);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte(tkbd_pkg::C_TILDE);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte({tkbd_pkg::C_DIGIT_HN, 4'd9});
        send_byte(tkbd_pkg::C_TILDE);
        wait_drained();
    endtask

    // Broken sequences: replay of held bytes, ESC restart, digit overflow,
    // escape in the middle of a UTF-8 character
    task automatic test_escape_mismatch();
        send_byte(tkbd_pkg::C_ESC);
        send_byte(8'h78);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte(tkbd_pkg::C_FIN_B);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_SS3_O);
        send_byte({tkbd_pkg::C_DIGIT_HN, 4'd1});
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_digits(MAX_DIGITS + 1);
        send_byte(8'hC3);
        send_byte(tkbd_pkg::C_ESC);
        send_byte(tkbd_pkg::C_LBRACKET);
        send_byte(tkbd_pkg::C_FIN_D);
        send_byte(8'hA9);
        wait_drained();
    endtask

    // Mostly well-formed keys and characters, some broken input and noise;
    // idling switches off for stretches
    task automatic test_random_stream();
        int stop_at;
        int r;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            gaps_on = ((bytes_sent / 60) % 4) != 1;
            r = $urandom_range(0, 99);
            if (r < 30)
                send_escape_good();
            else if (r < 60)
                send_utf8_good();
            else if (r < 68)
                send_byte(($urandom_range(0, 1) == 0) ?
                          (($urandom_range(0, 1) == 0) ? tkbd_pkg::C_CR : tkbd_pkg::C_LF) :
                          (($urandom_range(0, 1) == 0) ? tkbd_pkg::C_DEL : tkbd_pkg::C_BS));
            else if (r < 78)
                send_escape_broken();
            else if (r < 86)
                send_utf8_broken();
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_keys();
        test_utf8_decode();
        test_escape_keys();
        test_escape_mismatch();
        test_random_stream();
        if (expected_keys.size() != 0) begin
            $error("%0d predicted key events never arrived", expected_keys.size());
            fail_count++;
        end
        $display("Fed %0d terminal bytes: control keys, UTF-8 of every length, cursor",
                 bytes_sent);
        $display("and numeric escapes, broken sequences and noise; %0d key events checked.",
                 events_checked);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
